@@ rtl/pamu_pkg.sv @@
// ----------------------------------------------------------------------------
// pamu_pkg: shared definitions for the pitot airspeed moving average unit
// Widths, reset values, register indexes and the types that pass between the
// front end, the pending queue and the back end.
// ----------------------------------------------------------------------------
package pamu_pkg;

   localparam int PRESSURE_W   = 18;
   localparam int OFFSET_W     = 16;
   localparam int GAIN_W       = 10;
   localparam int SPEED_W      = 17;
   localparam int RADICAND_W   = 17;
   localparam int ROOT_W       = 9;
   localparam int ROOT_STEPS   = 9;
   localparam int PRODUCT_W    = ROOT_W + GAIN_W;
   localparam int TOTAL_W      = 21;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;
   localparam int QUEUE_DEPTH  = 2;

   localparam int DEFAULT_WINDOW_LENGTH = 10;

   localparam logic [OFFSET_W-1:0] ZERO_OFFSET_RESET = 16'd655;
   localparam logic [GAIN_W-1:0]   SPEED_GAIN_RESET  = 10'd240;
   localparam logic [SPEED_W-1:0]  SPEED_MAX         = '1;

   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_OFFSET = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_GAIN  = 2'd1;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_ROOT,
      BK_MUL,
      BK_ACC,
      BK_DIV,
      BK_OUT
   } back_state_type;

   typedef struct packed {
      logic                  push;
      logic [RADICAND_W-1:0] radicand;
   } queue_write_type;

   typedef struct packed {
      logic                  valid;
      logic [RADICAND_W-1:0] radicand;
   } queue_read_type;

endpackage

@@ rtl/pitot_airspeed_moving_average_unit.sv @@
// ----------------------------------------------------------------------------
// pitot_airspeed_moving_average_unit: pitot airspeed with moving average
// Converts differential pitot pressure samples to speed and reports the mean
// of the most recent WINDOW_LENGTH speeds.
// ----------------------------------------------------------------------------
// Each input transaction carries one signed Q16 psi pressure sample and
// produces exactly one result transaction with the windowed mean speed in
// 1/256 mph. Negative samples count as zero speed; otherwise the zero offset
// is removed (floored at zero), the floor square root is taken, scaled by the
// speed gain and saturated to 17 bits. The history ring and running total
// start cleared after reset. For each transaction the back end takes it from
// the queue, runs the bit-serial square root, does the gain multiply, updates
// the ring and total, forms the mean with the reciprocal multiply and loads
// the result register; the square root iterations take most of that time. It
// takes no new transaction before that load, and waits at the load while an
// earlier result is not yet popped. A two-entry queue sits between the
// intake and the back end, so new samples are taken while a result waits to
// be popped. Configuration writes to zero_offset (index 0) and speed_gain
// (index 1) take effect at once and belong to idle periods; other indexes
// are ignored.
// ----------------------------------------------------------------------------
module pitot_airspeed_moving_average_unit
   import pamu_pkg::*;
#(
   parameter int WINDOW_LENGTH = DEFAULT_WINDOW_LENGTH
)
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic signed [PRESSURE_W-1:0] req_pressure_sample,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [SPEED_W-1:0]           rsp_average_speed,
   input  logic                         csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_write_data
);

   // Configuration registers, written directly by the CSR port.
   logic [OFFSET_W-1:0] zero_offset_ff, zero_offset_in;
   logic [GAIN_W-1:0]   speed_gain_ff, speed_gain_in;

   queue_write_type queue_write;
   queue_read_type  queue_read;
   logic            queue_full;
   logic            queue_pop;

   always_comb begin
      zero_offset_in = zero_offset_ff;
      speed_gain_in  = speed_gain_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ZERO_OFFSET: zero_offset_in = csr_write_data[OFFSET_W-1:0];
            CSR_SPEED_GAIN:  speed_gain_in  = csr_write_data[GAIN_W-1:0];
            default: begin
               // Writes to unassigned indexes are dropped.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_offset_ff <= ZERO_OFFSET_RESET;
         speed_gain_ff  <= SPEED_GAIN_RESET;
      end else begin
         zero_offset_ff <= zero_offset_in;
         speed_gain_ff  <= speed_gain_in;
      end
   end

   // The intake is ready whenever the pending queue has room.
   assign req_full = queue_full;

   pamu_front u_front (
      .req_push            (req_push),
      .req_pressure_sample (req_pressure_sample),
      .zero_offset         (zero_offset_ff),
      .queue_full          (queue_full),
      .write_out           (queue_write)
   );

   pamu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .write_in (queue_write),
      .pop      (queue_pop),
      .full     (queue_full),
      .read_out (queue_read)
   );

   pamu_back #(
      .WINDOW_LENGTH (WINDOW_LENGTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .read_in           (queue_read),
      .queue_pop         (queue_pop),
      .speed_gain        (speed_gain_ff),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_average_speed (rsp_average_speed)
   );

endmodule

@@ rtl/pamu_front.sv @@
// ----------------------------------------------------------------------------
// pamu_front: input classification
// Accepts pressure samples, zeroes negative ones and removes the zero offset,
// floored at zero, to form the radicand for the square root.
// ----------------------------------------------------------------------------
module pamu_front
   import pamu_pkg::*;
(
   input  logic                         req_push,
   input  logic signed [PRESSURE_W-1:0] req_pressure_sample,
   input  logic [OFFSET_W-1:0]          zero_offset,
   input  logic                         queue_full,
   output queue_write_type              write_out
);

   logic                  negative;
   logic [RADICAND_W-1:0] magnitude;
   logic [RADICAND_W-1:0] offset_ext;

   assign negative   = req_pressure_sample[PRESSURE_W-1];
   assign magnitude  = req_pressure_sample[RADICAND_W-1:0];
   assign offset_ext = {{(RADICAND_W-OFFSET_W){1'b0}}, zero_offset};

   always_comb begin
      write_out.push = req_push & ~queue_full;
      if (negative || (magnitude <= offset_ext)) begin
         write_out.radicand = '0;
      end else begin
         write_out.radicand = magnitude - offset_ext;
      end
   end

endmodule

@@ rtl/pamu_queue.sv @@
// ----------------------------------------------------------------------------
// pamu_queue: pending radicand queue
// A short FIFO that decouples sample intake from the square root back end.
// ----------------------------------------------------------------------------
module pamu_queue
   import pamu_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  queue_write_type write_in,
   input  logic            pop,
   output logic            full,
   output queue_read_type  read_out
);

   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [RADICAND_W-1:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic                  do_pop;

   assign full              = (count_ff == COUNT_W'(QUEUE_DEPTH));
   assign read_out.valid    = (count_ff != '0);
   assign read_out.radicand = entry_ff[rd_ptr_ff];
   assign do_pop            = pop & read_out.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (write_in.push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (write_in.push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!write_in.push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (write_in.push) begin
         entry_ff[wr_ptr_ff] <= write_in.radicand;
      end
   end

endmodule

@@ rtl/pamu_back.sv @@
// ----------------------------------------------------------------------------
// pamu_back: speed computation and moving average
// Bit-serial square root, gain multiply with saturation, history ring update
// and a reciprocal multiply for the window mean, ending in a result register.
// ----------------------------------------------------------------------------
module pamu_back
   import pamu_pkg::*;
#(
   parameter int WINDOW_LENGTH = DEFAULT_WINDOW_LENGTH
)
(
   input  logic                clock,
   input  logic                reset,
   input  queue_read_type      read_in,
   output logic                queue_pop,
   input  logic [GAIN_W-1:0]   speed_gain,
   input  logic                rsp_pop,
   output logic                rsp_empty,
   output logic [SPEED_W-1:0]  rsp_average_speed
);

   localparam int SLOT_W = $clog2(WINDOW_LENGTH);
   localparam int CNT_W  = $clog2(ROOT_STEPS + 1);
   localparam logic [RADICAND_W-1:0] ROOT_TOP = RADICAND_W'(1) << (2 * (ROOT_STEPS - 1));

   // The mean is floor(total * RECIP / 2^DIV_SHIFT), with RECIP rounded up.
   // This is exact for every total below 2^TOTAL_W.
   localparam int DIV_SHIFT = TOTAL_W + $clog2(WINDOW_LENGTH);
   localparam int RECIP_W   = TOTAL_W + 1;
   localparam int SCALED_W  = TOTAL_W + RECIP_W;
   localparam longint unsigned RECIP_FULL =
      ((64'd1 << DIV_SHIFT) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

   back_state_type        state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [RADICAND_W-1:0] rem_ff, rem_in;
   logic [RADICAND_W-1:0] res_ff, res_in;
   logic [RADICAND_W-1:0] bit_ff, bit_in;
   logic [SPEED_W-1:0]    speed_ff, speed_in;
   logic [SPEED_W-1:0]    history_ff [WINDOW_LENGTH];
   logic [SPEED_W-1:0]    history_in [WINDOW_LENGTH];
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [TOTAL_W-1:0]    total_ff, total_in;
   logic [SPEED_W-1:0]    quot_ff, quot_in;
   logic                  out_valid_ff, out_valid_in;
   logic [SPEED_W-1:0]    out_data_ff, out_data_in;

   logic [RADICAND_W:0]   trial;
   logic [PRODUCT_W-1:0]  product;
   logic [SCALED_W-1:0]   scaled;

   assign rsp_empty         = ~out_valid_ff;
   assign rsp_average_speed = out_data_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      speed_in     = speed_ff;
      history_in   = history_ff;
      slot_in      = slot_ff;
      total_in     = total_ff;
      quot_in      = quot_ff;
      out_valid_in = out_valid_ff & ~rsp_pop;
      out_data_in  = out_data_ff;
      queue_pop    = 1'b0;

      trial   = {1'b0, res_ff} + {1'b0, bit_ff};
      product = res_ff[ROOT_W-1:0] * speed_gain;
      scaled  = total_ff * RECIP;

      unique case (state_ff)
         BK_IDLE: begin
            if (read_in.valid) begin
               queue_pop = 1'b1;
               rem_in    = read_in.radicand;
               res_in    = '0;
               bit_in    = ROOT_TOP;
               cnt_in    = '0;
               state_in  = BK_ROOT;
            end
         end
         BK_ROOT: begin
            if ({1'b0, rem_ff} >= trial) begin
               rem_in = rem_ff - trial[RADICAND_W-1:0];
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (cnt_ff == CNT_W'(ROOT_STEPS - 1)) begin
               state_in = BK_MUL;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         BK_MUL: begin
            if (product > PRODUCT_W'(SPEED_MAX)) begin
               speed_in = SPEED_MAX;
            end else begin
               speed_in = product[SPEED_W-1:0];
            end
            state_in = BK_ACC;
         end
         BK_ACC: begin
            total_in = total_ff - TOTAL_W'(history_ff[slot_ff]) + TOTAL_W'(speed_ff);
            history_in[slot_ff] = speed_ff;
            slot_in  = (slot_ff == SLOT_W'(WINDOW_LENGTH - 1)) ? '0 : slot_ff + 1'b1;
            state_in = BK_DIV;
         end
         BK_DIV: begin
            quot_in  = scaled[DIV_SHIFT +: SPEED_W];
            state_in = BK_OUT;
         end
         BK_OUT: begin
            if (!out_valid_ff || rsp_pop) begin
               out_valid_in = 1'b1;
               out_data_in  = quot_ff;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         cnt_ff       <= '0;
         slot_ff      <= '0;
         total_ff     <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < WINDOW_LENGTH; i++) begin
            history_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         slot_ff      <= slot_in;
         total_ff     <= total_in;
         out_valid_ff <= out_valid_in;
         history_ff   <= history_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      res_ff      <= res_in;
      bit_ff      <= bit_in;
      speed_ff    <= speed_in;
      quot_ff     <= quot_in;
      out_data_ff <= out_data_in;
   end

endmodule
